FILE: rtl/core/civ_pkg.sv
// Shared constants and small tables for the civil date day offset pipeline.
package civ_pkg;

    // Pipeline shape: forward (date to count) stages, then inverse (count to date) stages.
    localparam int unsigned FWD_STAGES = 5;
    localparam int unsigned INV_STAGES = 8;
    localparam int unsigned NUM_STAGES = FWD_STAGES + INV_STAGES;

    // Calendar constants.
    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned DAYS_TO_EPOCH = 719468;

    // Forward path: year biased by 82 eras so the era split is unsigned.
    localparam int unsigned FWD_ERA_BIAS = 82;
    localparam int unsigned YEAR_BIAS    = FWD_ERA_BIAS * 400;
    // floor(v / 25) = (v * RECIP_25) >> 16, exact for v < 4681.
    localparam int unsigned RECIP_25     = 2622;
    // Count offset removed after era * 146097 + doe.
    localparam int unsigned COUNT_BIAS   = FWD_ERA_BIAS * DAYS_PER_ERA + DAYS_TO_EPOCH;

    // Inverse path: day count biased by 100 eras so the era split is unsigned.
    localparam int unsigned INV_ERA_BIAS = 100;
    // Added to ep + doe + offset: lands on (count + offset + epoch) + 100 eras.
    localparam int unsigned SHIFT_BIAS   = INV_ERA_BIAS * DAYS_PER_ERA
                                           - FWD_ERA_BIAS * DAYS_PER_ERA;
    // floor(2^32 / 146097): era estimate is exact or one low.
    localparam int unsigned RECIP_ERA    = 29398;
    // floor(x / 365) = (x * RECIP_365) >> 24, exact for x < 1.8M.
    localparam int unsigned RECIP_365    = 45965;
    // mp = ((5 * doy + 2) * 6854) >> 20 folded to doy * 34270 + 13708.
    localparam int unsigned MP_MUL       = 34270;
    localparam int unsigned MP_ADD       = 13708;
    localparam int unsigned YEAR_BIAS_INV = INV_ERA_BIAS * 400;

    // Days from March 1 to the start of shifted month mi: (153 * mi + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mi);
        logic [8:0] d;
        case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            4'd13:   d = 9'd398;
            4'd14:   d = 9'd428;
            4'd15:   d = 9'd459;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Whole centuries in a year of era (0..399).
    function automatic logic [1:0] centuries(input logic [8:0] yoe);
        logic [1:0] c;
        c = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
        return c;
    endfunction

endpackage

FILE: rtl/core/civ_fwd.sv
// Forward stages: civil date to day count, plus biased shifted count for the inverse.
module civ_fwd (
    input  logic                                clk,
    input  logic [civ_pkg::FWD_STAGES-1:0]      adv,
    input  logic [4:0]                          in_day,
    input  logic [3:0]                          in_month,
    input  logic signed [15:0]                  in_year,
    input  logic signed [20:0]                  day_offset,
    output logic signed [24:0]                  count,
    output logic [24:0]                         shifted
);

    // stage 0 comb
    logic                 le2;
    logic [3:0]           mi;
    logic signed [16:0]   y;
    logic [16:0]          u0_next;
    logic signed [9:0]    doy0_next;
    // stage 1 comb
    logic [24:0]          prod1;
    logic [7:0]           q1_next;
    // stage 2 comb
    logic [8:0]           yoe2_next;
    // stage 3 comb
    logic [18:0]          doe3_next;
    logic [24:0]          ep3_next;
    // stage 4 comb
    logic [24:0]          count4_next;
    logic [24:0]          shift4_next;

    logic [16:0]          u0_reg, u1_reg;
    logic signed [9:0]    doy0_reg, doy1_reg, doy2_reg;
    logic signed [20:0]   off0_reg, off1_reg, off2_reg, off3_reg;
    logic [7:0]           q1_reg, q2_reg;
    logic [8:0]           yoe2_reg;
    logic [18:0]          doe3_reg;
    logic [24:0]          ep3_reg;
    logic [24:0]          count4_reg;
    logic [24:0]          shift4_reg;

    // March-based year; January and February (and month zero) belong to the prior year
    always_comb
    begin
        le2       = (in_month <= 4'd2);
        mi        = le2 ? (in_month + 4'd9) : (in_month - 4'd3);
        y         = $signed({in_year[15], in_year}) - $signed({16'd0, le2});
        u0_next   = unsigned'(y) + 17'(civ_pkg::YEAR_BIAS);
        doy0_next = 10'($signed({1'b0, civ_pkg::month_start(mi)})
                        + $signed({5'd0, in_day}) - 10'sd1);
    end

    // era = u / 400 as (u >> 4) / 25
    always_comb
    begin
        prod1   = {12'd0, u0_reg[16:4]} * 25'(civ_pkg::RECIP_25);
        q1_next = prod1[23:16];
    end

    assign yoe2_next = 9'(u1_reg - ({9'd0, q1_reg} * 17'd400));

    always_comb
    begin
        doe3_next = ({10'd0, yoe2_reg} * 19'd365)
                    + {12'd0, yoe2_reg[8:2]}
                    - {17'd0, civ_pkg::centuries(yoe2_reg)}
                    + {{9{doy2_reg[9]}}, doy2_reg};
        ep3_next  = {17'd0, q2_reg} * 25'(civ_pkg::DAYS_PER_ERA);
    end

    // 27-bit modular sums, truncated to 25 bits
    always_comb
    begin
        count4_next = 25'({2'b00, ep3_reg} + {{8{doe3_reg[18]}}, doe3_reg}
                          - 27'(civ_pkg::COUNT_BIAS));
        shift4_next = 25'({2'b00, ep3_reg} + {{8{doe3_reg[18]}}, doe3_reg}
                          + {{6{off3_reg[20]}}, off3_reg}
                          + 27'(civ_pkg::SHIFT_BIAS));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            u0_reg   <= u0_next;
            doy0_reg <= doy0_next;
            off0_reg <= day_offset;
        end
        if (adv[1])
        begin
            q1_reg   <= q1_next;
            u1_reg   <= u0_reg;
            doy1_reg <= doy0_reg;
            off1_reg <= off0_reg;
        end
        if (adv[2])
        begin
            yoe2_reg <= yoe2_next;
            q2_reg   <= q1_reg;
            doy2_reg <= doy1_reg;
            off2_reg <= off1_reg;
        end
        if (adv[3])
        begin
            doe3_reg <= doe3_next;
            ep3_reg  <= ep3_next;
            off3_reg <= off2_reg;
        end
        if (adv[4])
        begin
            count4_reg <= count4_next;
            shift4_reg <= shift4_next;
        end
    end

    assign count   = $signed(count4_reg);
    assign shifted = shift4_reg;

endmodule

FILE: rtl/core/civ_inv.sv
// Inverse stages: biased day count back to year, month and day; carries day count along.
module civ_inv (
    input  logic                                clk,
    input  logic [civ_pkg::INV_STAGES-1:0]      adv,
    input  logic signed [24:0]                  count,
    input  logic [24:0]                         shifted,
    output logic signed [24:0]                  day_number,
    output logic signed [16:0]                  out_year,
    output logic [3:0]                          out_month,
    output logic [4:0]                          out_day
);

    logic [39:0]          prod5;
    logic [7:0]           q5_next;
    logic [18:0]          r6_next;
    logic                 fix;
    logic [17:0]          doe7_next;
    logic [7:0]           q7_next;
    logic [31:0]          prod8;
    logic [6:0]           a8;
    logic [2:0]           b8;
    logic                 c8;
    logic [17:0]          t8_next;
    logic [33:0]          prod9;
    logic [8:0]           yoe9_next;
    logic [17:0]          base10;
    logic [8:0]           doy10_next;
    logic [24:0]          prod11;
    logic [3:0]           mp11_next;
    logic [3:0]           month12_next;
    logic                 le2;
    logic [8:0]           day12;
    logic [17:0]          year12;

    logic [24:0]          w5_reg;
    logic [7:0]           q5_reg, q6_reg, q7_reg, q8_reg, q9_reg, q10_reg, q11_reg;
    logic [18:0]          r6_reg;
    logic [17:0]          doe7_reg, doe8_reg, doe9_reg;
    logic [17:0]          t8_reg;
    logic [8:0]           yoe9_reg, yoe10_reg, yoe11_reg;
    logic [8:0]           doy10_reg, doy11_reg;
    logic [3:0]           mp11_reg;
    logic signed [24:0]   cnt5_reg, cnt6_reg, cnt7_reg, cnt8_reg, cnt9_reg, cnt10_reg;
    logic signed [24:0]   cnt11_reg, cnt12_reg;
    logic signed [16:0]   year12_reg;
    logic [3:0]           month12_reg;
    logic [4:0]           day12_reg;

    // era estimate, exact or one low
    always_comb
    begin
        prod5   = {15'd0, shifted} * 40'(civ_pkg::RECIP_ERA);
        q5_next = prod5[39:32];
    end

    assign r6_next = 19'(w5_reg - ({17'd0, q5_reg} * 25'(civ_pkg::DAYS_PER_ERA)));

    always_comb
    begin
        fix       = (r6_reg >= 19'(civ_pkg::DAYS_PER_ERA));
        doe7_next = fix ? 18'(r6_reg - 19'(civ_pkg::DAYS_PER_ERA)) : r6_reg[17:0];
        q7_next   = q6_reg + {7'd0, fix};
    end

    // doe - doe/1460 + doe/36524 - doe/146096
    always_comb
    begin
        prod8   = {16'd0, doe7_reg[17:2]} * 32'(civ_pkg::RECIP_365);
        a8      = prod8[30:24];
        b8      = 3'(doe7_reg >= 18'd36524) + 3'(doe7_reg >= 18'd73048)
                  + 3'(doe7_reg >= 18'd109572) + 3'(doe7_reg >= 18'd146096);
        c8      = (doe7_reg == 18'd146096);
        t8_next = doe7_reg - {11'd0, a8} + {15'd0, b8} - {17'd0, c8};
    end

    always_comb
    begin
        prod9     = {16'd0, t8_reg} * 34'(civ_pkg::RECIP_365);
        yoe9_next = prod9[32:24];
    end

    always_comb
    begin
        base10     = ({9'd0, yoe9_reg} * 18'd365) + {11'd0, yoe9_reg[8:2]}
                     - {16'd0, civ_pkg::centuries(yoe9_reg)};
        doy10_next = 9'(doe9_reg - base10);
    end

    always_comb
    begin
        prod11    = ({16'd0, doy10_reg} * 25'(civ_pkg::MP_MUL)) + 25'(civ_pkg::MP_ADD);
        mp11_next = prod11[23:20];
    end

    always_comb
    begin
        month12_next = (mp11_reg < 4'd10) ? (mp11_reg + 4'd3) : (mp11_reg - 4'd9);
        le2          = (month12_next <= 4'd2);
        day12        = doy11_reg - civ_pkg::month_start(mp11_reg) + 9'd1;
        year12       = {9'd0, yoe11_reg} + ({10'd0, q11_reg} * 18'd400)
                       - 18'(civ_pkg::YEAR_BIAS_INV) + {17'd0, le2};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            q5_reg   <= q5_next;
            w5_reg   <= shifted;
            cnt5_reg <= count;
        end
        if (adv[1])
        begin
            r6_reg   <= r6_next;
            q6_reg   <= q5_reg;
            cnt6_reg <= cnt5_reg;
        end
        if (adv[2])
        begin
            doe7_reg <= doe7_next;
            q7_reg   <= q7_next;
            cnt7_reg <= cnt6_reg;
        end
        if (adv[3])
        begin
            t8_reg   <= t8_next;
            doe8_reg <= doe7_reg;
            q8_reg   <= q7_reg;
            cnt8_reg <= cnt7_reg;
        end
        if (adv[4])
        begin
            yoe9_reg <= yoe9_next;
            doe9_reg <= doe8_reg;
            q9_reg   <= q8_reg;
            cnt9_reg <= cnt8_reg;
        end
        if (adv[5])
        begin
            doy10_reg <= doy10_next;
            yoe10_reg <= yoe9_reg;
            q10_reg   <= q9_reg;
            cnt10_reg <= cnt9_reg;
        end
        if (adv[6])
        begin
            mp11_reg  <= mp11_next;
            doy11_reg <= doy10_reg;
            yoe11_reg <= yoe10_reg;
            q11_reg   <= q10_reg;
            cnt11_reg <= cnt10_reg;
        end
        if (adv[7])
        begin
            year12_reg  <= $signed(year12[16:0]);
            month12_reg <= month12_next;
            day12_reg   <= day12[4:0];
            cnt12_reg   <= cnt11_reg;
        end
    end

    assign day_number = cnt12_reg;
    assign out_year   = year12_reg;
    assign out_month  = month12_reg;
    assign out_day    = day12_reg;

endmodule

FILE: rtl/core/civil_date_day_offset_core.sv
// Top level: pipelined civil date to day count converter with day offset and back.
//
//  beat     | valid         | stall          | payload
//  ---------+---------------+----------------+-------------------------------------------
//  date     | date_valid    | date_stall     | in_day, in_month, in_year, day_offset
//  result   | result_valid  | result_stall   | day_number, out_year, out_month, out_day
//
// Thirteen register stages, five forward (date to count) and eight inverse (count to date);
// one beat enters per cycle while date_stall is low. Throughput is one beat per cycle
// when the result is not stalled, since no stage iterates; the 25x15 era reciprocal
// multiply is the deepest stage and bounds the clock period.
// Reset clears only the per-stage valid bits; datapath registers are not reset.
// A stalled result holds in the last stage while earlier stages keep filling bubbles;
// date_stall rises only when every stage holds a beat and the result is stalled.
module civil_date_day_offset_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 date_valid,
    output logic                 date_stall,
    input  logic [4:0]           in_day,
    input  logic [3:0]           in_month,
    input  logic signed [15:0]   in_year,
    input  logic signed [20:0]   day_offset,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic signed [24:0]   day_number,
    output logic signed [16:0]   out_year,
    output logic [3:0]           out_month,
    output logic [4:0]           out_day
);

    localparam int unsigned N = civ_pkg::NUM_STAGES;
    localparam int unsigned F = civ_pkg::FWD_STAGES;

    logic [N-1:0]         valid_reg;
    logic [N-1:0]         valid_next;
    logic [N-1:0]         ready;
    logic signed [24:0]   count;
    logic [24:0]          shifted;
    logic                 in_acc;
    logic                 out_acc;

    // A stage may load when it is empty or some stage downstream of it can move.
    genvar g;
    for (g = 0; g < N; g++)
    begin : g_ready
        assign ready[g] = ~(result_stall & (&valid_reg[N-1:g]));
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? date_valid : valid_reg[0];
        for (int i = 1; i < N; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign date_stall   = ~ready[0];
    assign result_valid = valid_reg[N-1];
    assign in_acc       = date_valid & ~date_stall;
    assign out_acc      = result_valid & ~result_stall;

    civ_fwd u_fwd (
        .clk        (clk),
        .adv        (ready[F-1:0]),
        .in_day     (in_day),
        .in_month   (in_month),
        .in_year    (in_year),
        .day_offset (day_offset),
        .count      (count),
        .shifted    (shifted)
    );

    civ_inv u_inv (
        .clk        (clk),
        .adv        (ready[N-1:F]),
        .count      (count),
        .shifted    (shifted),
        .day_number (day_number),
        .out_year   (out_year),
        .out_month  (out_month),
        .out_day    (out_day)
    );

    // Input backpressure only when the whole pipe is full behind a stalled result.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        date_stall |-> ((&valid_reg) && result_stall))
        else $error("date_stall with a free stage");

    // Beats in flight change only by accepted inputs and delivered results.
    a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + $past(32'(in_acc)) - $past(32'(out_acc))))
        else $error("beat lost or duplicated in pipeline");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((out_month >= 4'd1) && (out_month <= 4'd12)))
        else $error("shifted month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (out_day != 5'd0))
        else $error("shifted day is zero");

endmodule
